@@ design/anrm_pkg.sv @@
// ----------------------------------------------------------------------------
// anrm_pkg
// Shared types, constants and field-check functions for the ARP / NDP reply
// matcher.
// ----------------------------------------------------------------------------
package anrm_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
    localparam int MAC_W           = 48;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 64;

    localparam int ARP_MIN_LEN = 42;
    localparam int NDP_MIN_LEN = 86;

    localparam logic [7:0] ETH_TYPE_HI_ARP = 8'h08;
    localparam logic [7:0] ETH_TYPE_LO_ARP = 8'h06;
    localparam logic [7:0] ARP_OPER_HI     = 8'h00;
    localparam logic [7:0] ARP_OPER_REPLY  = 8'h02;
    localparam logic [7:0] ETH_TYPE_HI_V6  = 8'h86;
    localparam logic [7:0] ETH_TYPE_LO_V6  = 8'hdd;
    localparam logic [7:0] NEXT_HDR_ICMPV6 = 8'd58;
    localparam logic [7:0] ICMPV6_NA       = 8'd136;
    localparam logic [7:0] OPT_TYPE_TLLA   = 8'd2;
    localparam logic [7:0] OPT_LEN_ONE     = 8'd1;

    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESOLVE_MODE     = CFG_IDX_W'(0),
        CFG_OWN_IPV4         = CFG_IDX_W'(1),
        CFG_TARGET_ADDR_HIGH = CFG_IDX_W'(2),
        CFG_TARGET_ADDR_LOW  = CFG_IDX_W'(3)
    } t_cfg_idx;

    typedef struct packed {
        logic        resolve_mode;
        logic [31:0] own_ipv4;
        logic [63:0] target_addr_high;
        logic [63:0] target_addr_low;
    } t_cfg;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_byte_item;

    typedef struct packed {
        logic             matched;
        logic [MAC_W-1:0] peer_mac;
    } t_result;

    typedef struct packed {
        logic       check;
        logic [7:0] want;
    } t_expect;

    function automatic logic [7:0] byte_of64(logic [63:0] v, t_pos pos, t_pos first);
        t_pos       d;
        logic [2:0] k;
        d = pos - first;
        k = d[2:0];
        return v[(7 - int'(k)) * 8 +: 8];
    endfunction

    function automatic logic [7:0] byte_of32(logic [31:0] v, t_pos pos, t_pos first);
        t_pos       d;
        logic [1:0] k;
        d = pos - first;
        k = d[1:0];
        return v[(3 - int'(k)) * 8 +: 8];
    endfunction

    function automatic t_expect expected_byte(logic mode, t_pos pos, t_cfg cfg);
        t_expect e;
        e.check = 1'b1;
        e.want  = 8'h00;
        if (!mode) begin
            case (pos) inside
                12:      e.want = ETH_TYPE_HI_ARP;
                13:      e.want = ETH_TYPE_LO_ARP;
                20:      e.want = ARP_OPER_HI;
                21:      e.want = ARP_OPER_REPLY;
                [28:31]: e.want = byte_of32(cfg.target_addr_low[31:0], pos, t_pos'(28));
                [38:41]: e.want = byte_of32(cfg.own_ipv4, pos, t_pos'(38));
                default: e.check = 1'b0;
            endcase
        end else begin
            case (pos) inside
                12:      e.want = ETH_TYPE_HI_V6;
                13:      e.want = ETH_TYPE_LO_V6;
                20:      e.want = NEXT_HDR_ICMPV6;
                54:      e.want = ICMPV6_NA;
                [22:29]: e.want = byte_of64(cfg.target_addr_high, pos, t_pos'(22));
                [30:37]: e.want = byte_of64(cfg.target_addr_low, pos, t_pos'(30));
                [62:69]: e.want = byte_of64(cfg.target_addr_high, pos, t_pos'(62));
                [70:77]: e.want = byte_of64(cfg.target_addr_low, pos, t_pos'(70));
                default: e.check = 1'b0;
            endcase
        end
        return e;
    endfunction

endpackage

@@ design/anrm_byte_if.sv @@
// ----------------------------------------------------------------------------
// anrm_byte_if
// Channel that carries one received frame byte per transaction.
// ----------------------------------------------------------------------------
interface anrm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

@@ design/anrm_result_if.sv @@
// ----------------------------------------------------------------------------
// anrm_result_if
// Channel that carries one match result per frame.
// ----------------------------------------------------------------------------
interface anrm_result_if;
    import anrm_pkg::*;
    logic             valid;
    logic             ready;
    logic             matched;
    logic [MAC_W-1:0] peer_mac;

    modport source (output valid, output matched, output peer_mac, input ready);
    modport sink   (input valid, input matched, input peer_mac, output ready);
endinterface

@@ design/anrm_byte_reg.sv @@
// ----------------------------------------------------------------------------
// anrm_byte_reg
// Input register for frame bytes. A byte leaves when the checker takes it;
// a last byte waits until the result register has room.
// ----------------------------------------------------------------------------
module anrm_byte_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  anrm_pkg::t_byte_item  i_item,
    output logic                  o_ready,
    input  logic                  i_out_free,
    output logic                  o_advance,
    output anrm_pkg::t_byte_item  o_item
);
    import anrm_pkg::*;

    logic       r_valid;
    t_byte_item r_item;

    assign o_advance = r_valid && (!r_item.last_byte || i_out_free);
    assign o_ready   = !r_valid || o_advance;
    assign o_item    = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end
endmodule

@@ design/anrm_frame_check.sv @@
// ----------------------------------------------------------------------------
// anrm_frame_check
// Per-frame state: byte position, field checks and link address capture.
// Produces the result for the frame when its last byte is taken.
// ----------------------------------------------------------------------------
module anrm_frame_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  anrm_pkg::t_cfg        i_cfg,
    input  logic                  i_advance,
    input  anrm_pkg::t_byte_item  i_item,
    output anrm_pkg::t_result     o_result
);
    import anrm_pkg::*;

    t_pos             r_pos;
    logic             r_fields_ok;
    logic [MAC_W-1:0] r_primary_mac;
    logic [MAC_W-1:0] r_option_mac;
    logic             r_opt_hdr_ok;

    t_pos             n_pos;
    logic             n_fields_ok;
    logic [MAC_W-1:0] n_primary_mac;
    logic [MAC_W-1:0] n_option_mac;
    logic             n_opt_hdr_ok;

    t_expect          exp_b;
    logic             mode;
    logic [7:0]       b;
    logic             len_ok;
    logic [MAC_W-1:0] mac;

    always_comb begin
        mode  = i_cfg.resolve_mode;
        b     = i_item.frame_byte;
        exp_b = expected_byte(mode, r_pos, i_cfg);

        n_fields_ok   = r_fields_ok && !(exp_b.check && (exp_b.want != b));
        n_primary_mac = r_primary_mac;
        n_option_mac  = r_option_mac;
        n_opt_hdr_ok  = r_opt_hdr_ok;

        if (!mode) begin
            if (r_pos inside {[22:27]}) begin
                n_primary_mac = {r_primary_mac[MAC_W-9:0], b};
            end
        end else begin
            if (r_pos inside {[6:11]}) begin
                n_primary_mac = {r_primary_mac[MAC_W-9:0], b};
            end
            if (r_pos == t_pos'(78)) begin
                n_opt_hdr_ok = (b == OPT_TYPE_TLLA);
            end
            if (r_pos == t_pos'(79)) begin
                n_opt_hdr_ok = r_opt_hdr_ok && (b == OPT_LEN_ONE);
            end
            if (r_pos inside {[80:85]}) begin
                n_option_mac = {r_option_mac[MAC_W-9:0], b};
            end
        end

        if (r_pos < t_pos'(MAX_FRAME_BYTES - 1)) begin
            n_pos = r_pos + t_pos'(1);
        end else begin
            n_pos = r_pos;
        end

        len_ok = mode ? (r_pos >= t_pos'(NDP_MIN_LEN - 1))
                      : (r_pos >= t_pos'(ARP_MIN_LEN - 1));
        mac    = (mode && n_opt_hdr_ok) ? n_option_mac : n_primary_mac;

        o_result.matched  = n_fields_ok && len_ok;
        o_result.peer_mac = o_result.matched ? mac : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_item.last_byte)) begin
            r_pos         <= '0;
            r_fields_ok   <= 1'b1;
            r_primary_mac <= '0;
            r_option_mac  <= '0;
            r_opt_hdr_ok  <= 1'b0;
        end else if (i_advance) begin
            r_pos         <= n_pos;
            r_fields_ok   <= n_fields_ok;
            r_primary_mac <= n_primary_mac;
            r_option_mac  <= n_option_mac;
            r_opt_hdr_ok  <= n_opt_hdr_ok;
        end
    end
endmodule

@@ design/anrm_result_reg.sv @@
// ----------------------------------------------------------------------------
// anrm_result_reg
// Output register holding one result until the sink takes it.
// ----------------------------------------------------------------------------
module anrm_result_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  anrm_pkg::t_result  i_result,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_free,
    output anrm_pkg::t_result  o_result
);
    import anrm_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_valid  = r_valid;
    assign o_free   = !r_valid || i_ready;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end
endmodule

@@ design/arp_ndp_reply_matcher.sv @@
// The last frame byte goes through the input register into the result register.
// Throughput: one frame byte per cycle, frames back to back, while results flow.
// A last byte waits in the input register only while an older result is stalled.
// Reset (synchronous, active low) clears the configuration registers, the
// per-frame state and both valid flags.
// ----------------------------------------------------------------------------
// arp_ndp_reply_matcher
// Checks received frames for an ARP reply or IPv6 neighbor advertisement that
// answers the pending resolution and returns the resolved link address.
// ----------------------------------------------------------------------------
module arp_ndp_reply_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [anrm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [anrm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    anrm_byte_if.sink                           i_byte_ch,
    anrm_result_if.source                       o_result_ch
);
    import anrm_pkg::*;

    t_cfg       r_cfg;
    t_byte_item in_item;
    t_byte_item chk_item;
    t_result    chk_result;
    t_result    out_result;
    logic       advance;
    logic       out_free;
    logic       in_ready;
    logic       out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RESOLVE_MODE:     r_cfg.resolve_mode     <= i_cfg_data[0];
                CFG_OWN_IPV4:         r_cfg.own_ipv4         <= i_cfg_data[31:0];
                CFG_TARGET_ADDR_HIGH: r_cfg.target_addr_high <= i_cfg_data;
                CFG_TARGET_ADDR_LOW:  r_cfg.target_addr_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.frame_byte = i_byte_ch.frame_byte;
    assign in_item.last_byte  = i_byte_ch.last_byte;
    assign i_byte_ch.ready    = in_ready;

    anrm_byte_reg u_byte_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_byte_ch.valid),
        .i_item     (in_item),
        .o_ready    (in_ready),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_item     (chk_item)
    );

    anrm_frame_check u_frame_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_advance (advance),
        .i_item    (chk_item),
        .o_result  (chk_result)
    );

    anrm_result_reg u_result_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && chk_item.last_byte),
        .i_result (chk_result),
        .i_ready  (o_result_ch.ready),
        .o_valid  (out_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_result_ch.valid    = out_valid;
    assign o_result_ch.matched  = out_result.matched;
    assign o_result_ch.peer_mac = out_result.peer_mac;
endmodule

@@ design/anrm_checker.sv @@
// ----------------------------------------------------------------------------
// anrm_checker
// Port-level checks on the reply matcher, bound to the top level.
// ----------------------------------------------------------------------------
module anrm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_matched,
    input logic [anrm_pkg::MAC_W-1:0]   i_peer_mac
);
    import anrm_pkg::*;

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_matched) && $stable(i_peer_mac))
        else $error("Stalled result changed.");

    a_no_match_zero_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_matched |-> i_peer_mac == '0)
        else $error("Unmatched result carries a link address.");
endmodule

bind arp_ndp_reply_matcher anrm_checker u_anrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result_ch.valid),
    .i_out_ready (o_result_ch.ready),
    .i_matched   (o_result_ch.matched),
    .i_peer_mac  (o_result_ch.peer_mac)
);

@@ sim/arp_ndp_reply_matcher_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_ndp_reply_matcher_checker
// Watches the configuration port and both channels of the reply matcher. It
// keeps its own copy of the registers and the per-frame state, works out the
// result that each final frame byte must produce, and compares every result
// transaction field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module arp_ndp_reply_matcher_checker
    import anrm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    anrm_byte_if                  i_byte_ch,
    anrm_result_if                i_result_ch,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic        ndp_mode;
    logic [31:0] own_addr;
    logic [63:0] peer_addr_hi;
    logic [63:0] peer_addr_lo;

    int          byte_pos;
    logic        fields_ok;
    logic [47:0] link_mac;
    logic [47:0] option_mac;
    logic        option_ok;

    t_result     pending_replies[$];
    int          mismatches = 0;

    function automatic bit field_check(input logic mode, input int pos, output logic [7:0] want);
        want        = 8'h00;
        field_check = 1'b1;
        if (!mode) begin
            if (pos == 12) want = ETH_TYPE_HI_ARP;
            else if (pos == 13) want = ETH_TYPE_LO_ARP;
            else if (pos == 20) want = ARP_OPER_HI;
            else if (pos == 21) want = ARP_OPER_REPLY;
            else if (pos >= 28 && pos <= 31) want = peer_addr_lo[8 * (31 - pos) +: 8];
            else if (pos >= 38 && pos <= 41) want = own_addr[8 * (41 - pos) +: 8];
            else field_check = 1'b0;
        end else begin
            if (pos == 12) want = ETH_TYPE_HI_V6;
            else if (pos == 13) want = ETH_TYPE_LO_V6;
            else if (pos == 20) want = NEXT_HDR_ICMPV6;
            else if (pos == 54) want = ICMPV6_NA;
            else if (pos >= 22 && pos <= 29) want = peer_addr_hi[8 * (29 - pos) +: 8];
            else if (pos >= 30 && pos <= 37) want = peer_addr_lo[8 * (37 - pos) +: 8];
            else if (pos >= 62 && pos <= 69) want = peer_addr_hi[8 * (69 - pos) +: 8];
            else if (pos >= 70 && pos <= 77) want = peer_addr_lo[8 * (77 - pos) +: 8];
            else field_check = 1'b0;
        end
    endfunction

    task automatic clear_frame();
        byte_pos   = 0;
        fields_ok  = 1'b1;
        link_mac   = '0;
        option_mac = '0;
        option_ok  = 1'b0;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        logic [7:0] want;
        t_result    res;
        if (field_check(ndp_mode, byte_pos, want) && want != b) fields_ok = 1'b0;
        if (!ndp_mode) begin
            if (byte_pos >= 22 && byte_pos <= 27) link_mac = {link_mac[39:0], b};
        end else begin
            if (byte_pos >= 6 && byte_pos <= 11) link_mac = {link_mac[39:0], b};
            if (byte_pos == 78) option_ok = (b == OPT_TYPE_TLLA);
            if (byte_pos == 79) option_ok = option_ok && (b == OPT_LEN_ONE);
            if (byte_pos >= 80 && byte_pos <= 85) option_mac = {option_mac[39:0], b};
        end
        if (!last) begin
            if (byte_pos < MAX_FRAME_BYTES - 1) byte_pos++;
        end else begin
            res.matched = fields_ok &&
                          (byte_pos + 1 >= (ndp_mode ? NDP_MIN_LEN : ARP_MIN_LEN));
            res.peer_mac = !res.matched ? '0 :
                           (ndp_mode && option_ok) ? option_mac : link_mac;
            pending_replies.push_back(res);
            clear_frame();
        end
    endtask

    task automatic compare_result(input logic got_matched, input logic [47:0] got_mac);
        t_result want_res;
        if (pending_replies.size() == 0) begin
            $error("result transaction with no frame outstanding: matched %0b, peer_mac %012h",
                   got_matched, got_mac);
            mismatches++;
        end else begin
            want_res = pending_replies.pop_front();
            if (got_matched !== want_res.matched) begin
                $error("matched: expected %0b, actual %0b", want_res.matched, got_matched);
                mismatches++;
            end
            if (got_mac !== want_res.peer_mac) begin
                $error("peer_mac: expected %012h, actual %012h",
                       want_res.peer_mac, got_mac);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ndp_mode     = 1'b0;
            own_addr     = '0;
            peer_addr_hi = '0;
            peer_addr_lo = '0;
            clear_frame();
            pending_replies.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RESOLVE_MODE:     ndp_mode     = i_cfg_data[0];
                    CFG_OWN_IPV4:         own_addr     = i_cfg_data[31:0];
                    CFG_TARGET_ADDR_HIGH: peer_addr_hi = i_cfg_data;
                    CFG_TARGET_ADDR_LOW:  peer_addr_lo = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result_ch.valid && i_result_ch.ready) begin
                compare_result(i_result_ch.matched, i_result_ch.peer_mac);
            end
            if (i_byte_ch.valid && i_byte_ch.ready) begin
                take_byte(i_byte_ch.frame_byte, i_byte_ch.last_byte);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_replies.size();
    end

endmodule

@@ sim/arp_ndp_reply_matcher_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_ndp_reply_matcher_test
// Feeds the reply matcher with directed and random ARP and neighbor
// advertisement frames, good, damaged and truncated, under a range of
// register settings and flow-control patterns, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module arp_ndp_reply_matcher_test;
    import anrm_pkg::*;

    typedef logic [7:0] t_frame[$];

    localparam int CYCLE_LIMIT        = 20000;
    localparam int SETTLE_CYCLES      = 6;
    localparam int HOLD_CYCLES        = 300;
    localparam int BYTES_PER_PHASE    = 140;
    localparam int FRAMES_PER_PHASE   = 2;
    localparam int FRAMES_PER_SETTING = 2;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic        tb_mode = 1'b0;
    logic [31:0] tb_own  = '0;
    logic [63:0] tb_hi   = '0;
    logic [63:0] tb_lo   = '0;

    int   idle_pct     = 0;
    int   stall_pct    = 0;
    logic hold_results = 1'b0;
    int   pending;
    int   fail_count;
    int   cycle_count  = 0;

    anrm_byte_if   byte_ch ();
    anrm_result_if result_ch ();

    arp_ndp_reply_matcher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_byte_ch   (byte_ch),
        .o_result_ch (result_ch)
    );

    arp_ndp_reply_matcher_checker u_reply_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_byte_ch    (byte_ch),
        .i_result_ch  (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                result_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_results = 1'b0;
            end
            result_ch.ready = !(stall_pct != 0 && $urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            CFG_RESOLVE_MODE:     tb_mode = data[0];
            CFG_OWN_IPV4:         tb_own  = data[31:0];
            CFG_TARGET_ADDR_HIGH: tb_hi   = data;
            CFG_TARGET_ADDR_LOW:  tb_lo   = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        byte_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_span(input t_frame f, input int from, input int upto);
        for (int i = from; i < upto; i++) begin
            @(negedge i_clk);
            while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                byte_ch.valid = 1'b0;
                @(negedge i_clk);
            end
            byte_ch.valid      = 1'b1;
            byte_ch.frame_byte = f[i];
            byte_ch.last_byte  = (i == f.size() - 1);
            do @(posedge i_clk); while (!byte_ch.ready);
        end
    endtask

    // opt_kind: 0 carries a target link-layer option, 1 has the right option
    // type with a wrong length, 2 has a wrong option type.
    function automatic t_frame build_reply(input logic ndp, input int len, input int opt_kind);
        t_frame f;
        for (int i = 0; i < len; i++) f.push_back(8'($urandom));
        if (!ndp) begin
            f[12] = ETH_TYPE_HI_ARP;
            f[13] = ETH_TYPE_LO_ARP;
            f[20] = ARP_OPER_HI;
            f[21] = ARP_OPER_REPLY;
            for (int k = 0; k < 4; k++) begin
                f[28 + k] = tb_lo[8 * (3 - k) +: 8];
                f[38 + k] = tb_own[8 * (3 - k) +: 8];
            end
        end else begin
            f[12] = ETH_TYPE_HI_V6;
            f[13] = ETH_TYPE_LO_V6;
            f[20] = NEXT_HDR_ICMPV6;
            f[54] = ICMPV6_NA;
            for (int k = 0; k < 8; k++) begin
                f[22 + k] = tb_hi[8 * (7 - k) +: 8];
                f[30 + k] = tb_lo[8 * (7 - k) +: 8];
                f[62 + k] = tb_hi[8 * (7 - k) +: 8];
                f[70 + k] = tb_lo[8 * (7 - k) +: 8];
            end
            f[78] = OPT_TYPE_TLLA;
            f[79] = OPT_LEN_ONE;
            if (opt_kind == 1) f[79] = OPT_LEN_ONE ^ 8'($urandom_range(1, 255));
            if (opt_kind == 2) f[78] = OPT_TYPE_TLLA ^ 8'($urandom_range(1, 255));
        end
        return f;
    endfunction

    function automatic logic [63:0] pick_addr();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic new_settings(input logic mode);
        settle();
        write_reg(CFG_RESOLVE_MODE, 64'(mode));
        write_reg(CFG_OWN_IPV4, pick_addr());
        write_reg(CFG_TARGET_ADDR_HIGH, pick_addr());
        write_reg(CFG_TARGET_ADDR_LOW, pick_addr());
    endtask

    task automatic send_random_frame(output int nbytes);
        t_frame f;
        int     kind;
        int     min_len;
        int     len;
        min_len = tb_mode ? NDP_MIN_LEN : ARP_MIN_LEN;
        len     = min_len + (($urandom_range(3) == 0) ? $urandom_range(64) : $urandom_range(3));
        kind    = $urandom_range(99);
        if (kind < 88) begin
            f = build_reply(tb_mode, len, $urandom_range(2));
            if (kind >= 65 && kind < 80) begin
                f[$urandom_range(min_len - 1)] ^= 8'($urandom_range(1, 255));
            end else if (kind >= 80) begin
                f = f[0 : $urandom_range(min_len - 2)];
            end
        end else if (kind < 94) begin
            f = build_reply(!tb_mode, (tb_mode ? ARP_MIN_LEN : NDP_MIN_LEN) + $urandom_range(3),
                            $urandom_range(2));
        end else begin
            len = $urandom_range(1, 120);
            for (int i = 0; i < len; i++) f.push_back(8'($urandom));
        end
        send_span(f, 0, f.size());
        nbytes = f.size();
    endtask

    initial begin
        t_frame f;
        int     nbytes;
        int     phase_bytes;
        int     phase_frames;

        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        byte_ch.valid      = 1'b0;
        byte_ch.frame_byte = '0;
        byte_ch.last_byte  = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Registers still at their reset values: an ARP reply for all-zero addresses matches.
        f = build_reply(1'b0, ARP_MIN_LEN, 0);
        send_span(f, 0, f.size());

        settle();
        write_reg(CFG_RESOLVE_MODE, 64'h0);
        write_reg(CFG_OWN_IPV4, 64'hffff_0000_c0a8_0001);
        write_reg(CFG_TARGET_ADDR_HIGH, {$urandom, $urandom});
        write_reg(CFG_TARGET_ADDR_LOW, 64'h1234_5678_0a00_0002);
        for (int i = CFG_TARGET_ADDR_LOW + 1; i < 2 ** CFG_IDX_W; i++) begin
            write_reg(CFG_IDX_W'(i), '1);
        end

        f = build_reply(1'b0, ARP_MIN_LEN, 0);
        send_span(f, 0, f.size());
        f = f[0 : ARP_MIN_LEN - 2];
        send_span(f, 0, f.size());
        f = build_reply(1'b0, ARP_MIN_LEN + 5, 0);
        f[21] = 8'h01;
        send_span(f, 0, f.size());
        f = build_reply(1'b0, ARP_MIN_LEN, 0);
        f[41] ^= 8'h01;
        send_span(f, 0, f.size());
        f = {8'hff};
        send_span(f, 0, f.size());
        f = {8'h00};
        send_span(f, 0, f.size());

        settle();
        write_reg(CFG_RESOLVE_MODE, 64'h1);
        write_reg(CFG_TARGET_ADDR_HIGH, '1);
        write_reg(CFG_TARGET_ADDR_LOW, '1);
        for (int k = 0; k < 3; k++) begin
            f = build_reply(1'b1, NDP_MIN_LEN, k);
            send_span(f, 0, f.size());
        end
        f = build_reply(1'b1, NDP_MIN_LEN, 0);
        f = f[0 : NDP_MIN_LEN - 2];
        send_span(f, 0, f.size());
        f = build_reply(1'b1, NDP_MIN_LEN, 0);
        f[54] = 8'd135;
        send_span(f, 0, f.size());
        f = build_reply(1'b0, NDP_MIN_LEN, 0);
        send_span(f, 0, f.size());

        settle();
        write_reg(CFG_TARGET_ADDR_HIGH, '0);
        write_reg(CFG_TARGET_ADDR_LOW, '0);
        f = build_reply(1'b1, NDP_MIN_LEN + 3, 0);
        send_span(f, 0, f.size());

        // The mode flips partway through a frame, in both directions.
        f = build_reply(1'b1, NDP_MIN_LEN, 0);
        send_span(f, 0, 40);
        settle();
        write_reg(CFG_RESOLVE_MODE, 64'h0);
        send_span(f, 40, f.size());
        f = build_reply(1'b0, ARP_MIN_LEN + 50, 0);
        send_span(f, 0, 30);
        settle();
        write_reg(CFG_RESOLVE_MODE, 64'h1);
        send_span(f, 30, f.size());

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            new_settings(1'(ph));
            if (ph == 0) begin
                hold_results = 1'b1;
                for (int i = 0; i < 30; i++) begin
                    f = {8'($urandom)};
                    send_span(f, 0, 1);
                end
            end
            phase_bytes  = 0;
            phase_frames = 0;
            while (phase_bytes < BYTES_PER_PHASE || phase_frames < FRAMES_PER_PHASE) begin
                if (phase_frames != 0 && phase_frames % FRAMES_PER_SETTING == 0) begin
                    new_settings(1'($urandom_range(1)));
                end
                send_random_frame(nbytes);
                phase_bytes += nbytes;
                phase_frames++;
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/anrm_pkg.sv
design/anrm_byte_if.sv
design/anrm_result_if.sv
design/anrm_byte_reg.sv
design/anrm_frame_check.sv
design/anrm_result_reg.sv
design/arp_ndp_reply_matcher.sv
design/anrm_checker.sv
sim/arp_ndp_reply_matcher_checker.sv
sim/arp_ndp_reply_matcher_test.sv
